### rtl/first_fit_free_list_allocator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the allocator. Expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ffa_pkg.sv
// ---------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the first-fit allocator modules.
// ---------------------------------------------------------------------------
package ffa_pkg;

  localparam int HeapGranules   = 8192;
  localparam int HeaderGranules = 3;
  localparam int GranW          = $clog2(HeapGranules);  // block index
  localparam int SizeW          = GranW + 1;             // sizes, break, limit
  localparam int AddrW          = 16;                    // byte offsets
  localparam int PayW           = SizeW + 3;             // granule * 8

  // block header entry
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             used;
    logic [GranW-1:0] nlink;
    logic [GranW-1:0] plink;
  } hdr_t;

  localparam int HdrW = $bits(hdr_t);

  // header memory access
  typedef struct packed {
    logic             we;
    logic             re;
    logic [GranW-1:0] addr;
    hdr_t             wdata;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_UNL_PR,
    ST_UNL_PRW,
    ST_UNL_N,
    ST_UNL_NW,
    ST_BRK,
    ST_FREE_CHK,
    ST_FREE_LNK,
    ST_FREE_W
  } state_t;

endpackage

### rtl/ffa_hdr_ram.sv
// ---------------------------------------------------------------------------
// ffa_hdr_ram
// Block header store: one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ffa_hdr_ram (
  input  logic              clk,
  input  ffa_pkg::mem_req_t req,
  output ffa_pkg::hdr_t     rdata
);
  import ffa_pkg::*;

  hdr_t mem [HeapGranules];
  hdr_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ffa_ctrl.sv
// ---------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: list walk, unlink, break carve and free push over the header RAM.
// ---------------------------------------------------------------------------
module ffa_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_func,
  input  logic [15:0]              in_req_size,
  input  logic [15:0]              in_free_addr,
  input  logic [ffa_pkg::SizeW-1:0] limit,
  output ffa_pkg::mem_req_t        mem_req,
  input  ffa_pkg::hdr_t            mem_rdata,
  output logic                     out_valid,
  output logic [15:0]              out_addr,
  output logic                     out_status,
  output logic                     out_from_list
);
  import ffa_pkg::*;

  `include "first_fit_free_list_allocator_top_assert.svh"

  state_t           state_r, state_nxt;
  logic             func_r, func_nxt;
  logic [SizeW-1:0] need_r, need_nxt;
  logic [GranW-1:0] blk_r, blk_nxt;      // walk pointer / freed block
  logic [SizeW-1:0] brk_r, brk_nxt;
  logic [GranW-1:0] head_r, head_nxt;
  logic [SizeW-1:0] steps_r, steps_nxt;
  hdr_t             hdr_r, hdr_nxt;      // header of the block taken off the list
  logic [GranW-1:0] link_r, link_nxt;    // old list head on free
  logic             out_valid_r, out_valid_nxt;
  logic [AddrW-1:0] out_addr_r, out_addr_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_from_list_r, out_from_list_nxt;

  logic [SizeW-1:0] need_c;
  logic [GranW-1:0] gran_c, bp_c;
  logic             free_ok_c;
  logic [SizeW-1:0] steps_inc;
  logic [SizeW:0]   brk_sum;
  logic [SizeW-1:0] lim_c;
  logic [PayW-1:0]  brk_pay, blk_pay;
  logic             brk_oom;

  assign need_c    = SizeW'(HeaderGranules) + SizeW'(in_req_size[15:3])
                   + SizeW'(|in_req_size[2:0]);
  assign gran_c    = in_free_addr[15:3];
  assign bp_c      = gran_c - GranW'(HeaderGranules);
  assign free_ok_c = (in_free_addr[2:0] == 3'b000)
                   && ({1'b0, gran_c} >= SizeW'(2 * HeaderGranules))
                   && ({1'b0, bp_c} < brk_r);

  assign steps_inc = steps_r + SizeW'(1);
  assign lim_c     = (limit > SizeW'(HeapGranules)) ? SizeW'(HeapGranules) : limit;
  assign brk_sum   = {1'b0, brk_r} + {1'b0, need_r};
  assign brk_pay   = {brk_r + SizeW'(HeaderGranules), 3'b000};
  assign blk_pay   = {SizeW'(blk_r) + SizeW'(HeaderGranules), 3'b000};
  // break past the limit, or offset not reachable in 16 bits
  assign brk_oom   = (brk_sum > {1'b0, lim_c}) || (|brk_pay[PayW-1:AddrW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      brk_r       <= SizeW'(HeaderGranules);
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      brk_r       <= brk_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r          <= func_nxt;
    need_r          <= need_nxt;
    blk_r           <= blk_nxt;
    steps_r         <= steps_nxt;
    hdr_r           <= hdr_nxt;
    link_r          <= link_nxt;
    out_addr_r      <= out_addr_nxt;
    out_status_r    <= out_status_nxt;
    out_from_list_r <= out_from_list_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    func_nxt          = func_r;
    need_nxt          = need_r;
    blk_nxt           = blk_r;
    brk_nxt           = brk_r;
    head_nxt          = head_r;
    steps_nxt         = steps_r;
    hdr_nxt           = hdr_r;
    link_nxt          = link_r;
    out_valid_nxt     = 1'b0;
    out_addr_nxt      = out_addr_r;
    out_status_nxt    = out_status_r;
    out_from_list_nxt = out_from_list_r;
    mem_req           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          need_nxt = need_c;
          if (!in_func) begin
            if (head_r != '0) begin
              mem_req.re   = 1'b1;
              mem_req.addr = head_r;
              blk_nxt      = head_r;
              steps_nxt    = '0;
              state_nxt    = ST_WALK;
            end else begin
              state_nxt = ST_BRK;
            end
          end else if (free_ok_c) begin
            mem_req.re   = 1'b1;
            mem_req.addr = bp_c;
            blk_nxt      = bp_c;
            state_nxt    = ST_FREE_CHK;
          end else begin
            // bad free address: ignored
            out_valid_nxt     = 1'b1;
            out_addr_nxt      = '0;
            out_status_nxt    = 1'b0;
            out_from_list_nxt = 1'b0;
          end
        end
      end

      ST_WALK: begin
        if (mem_rdata.size >= need_r) begin
          hdr_nxt            = mem_rdata;
          mem_req.we         = 1'b1;
          mem_req.addr       = blk_r;
          mem_req.wdata      = mem_rdata;
          mem_req.wdata.used = 1'b1;
          state_nxt          = ST_UNL_PR;
        end else if (mem_rdata.nlink == '0 || steps_inc == SizeW'(HeapGranules)) begin
          state_nxt = ST_BRK;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = mem_rdata.nlink;
          blk_nxt      = mem_rdata.nlink;
          steps_nxt    = steps_inc;
        end
      end

      ST_UNL_PR: begin
        if (hdr_r.plink == '0) begin
          head_nxt  = hdr_r.nlink;
          state_nxt = ST_UNL_N;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = hdr_r.plink;
          state_nxt    = ST_UNL_PRW;
        end
      end

      ST_UNL_PRW: begin
        mem_req.we          = 1'b1;
        mem_req.addr        = hdr_r.plink;
        mem_req.wdata       = mem_rdata;
        mem_req.wdata.nlink = hdr_r.nlink;
        state_nxt           = ST_UNL_N;
      end

      ST_UNL_N: begin
        if (hdr_r.nlink == '0) begin
          out_valid_nxt     = 1'b1;
          out_addr_nxt      = blk_pay[AddrW-1:0];
          out_status_nxt    = 1'b0;
          out_from_list_nxt = 1'b1;
          state_nxt         = ST_IDLE;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = hdr_r.nlink;
          state_nxt    = ST_UNL_NW;
        end
      end

      ST_UNL_NW: begin
        mem_req.we          = 1'b1;
        mem_req.addr        = hdr_r.nlink;
        mem_req.wdata       = mem_rdata;
        mem_req.wdata.plink = hdr_r.plink;
        out_valid_nxt       = 1'b1;
        out_addr_nxt        = blk_pay[AddrW-1:0];
        out_status_nxt      = 1'b0;
        out_from_list_nxt   = 1'b1;
        state_nxt           = ST_IDLE;
      end

      ST_BRK: begin
        out_valid_nxt     = 1'b1;
        out_from_list_nxt = 1'b0;
        state_nxt         = ST_IDLE;
        if (brk_oom) begin
          out_addr_nxt   = '0;
          out_status_nxt = 1'b1;
        end else begin
          mem_req.we            = 1'b1;
          mem_req.addr          = brk_r[GranW-1:0];
          mem_req.wdata.size    = need_r;
          mem_req.wdata.used    = 1'b1;
          mem_req.wdata.nlink   = '0;
          mem_req.wdata.plink   = '0;
          brk_nxt               = brk_sum[SizeW-1:0];
          out_addr_nxt          = brk_pay[AddrW-1:0];
          out_status_nxt        = 1'b0;
        end
      end

      ST_FREE_CHK: begin
        if (mem_rdata.used) begin
          mem_req.we          = 1'b1;
          mem_req.addr        = blk_r;
          mem_req.wdata.size  = mem_rdata.size;
          mem_req.wdata.used  = 1'b0;
          mem_req.wdata.nlink = head_r;
          mem_req.wdata.plink = '0;
          link_nxt            = head_r;
          head_nxt            = blk_r;
          state_nxt           = ST_FREE_LNK;
        end else begin
          // double free: ignored
          out_valid_nxt     = 1'b1;
          out_addr_nxt      = '0;
          out_status_nxt    = 1'b0;
          out_from_list_nxt = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end

      ST_FREE_LNK: begin
        if (link_r == '0) begin
          out_valid_nxt     = 1'b1;
          out_addr_nxt      = '0;
          out_status_nxt    = 1'b0;
          out_from_list_nxt = 1'b0;
          state_nxt         = ST_IDLE;
        end else begin
          mem_req.re   = 1'b1;
          mem_req.addr = link_r;
          state_nxt    = ST_FREE_W;
        end
      end

      ST_FREE_W: begin
        mem_req.we          = 1'b1;
        mem_req.addr        = link_r;
        mem_req.wdata       = mem_rdata;
        mem_req.wdata.plink = blk_r;
        out_valid_nxt       = 1'b1;
        out_addr_nxt        = '0;
        out_status_nxt      = 1'b0;
        out_from_list_nxt   = 1'b0;
        state_nxt           = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_addr      = out_addr_r;
  assign out_status    = out_status_r;
  assign out_from_list = out_from_list_r;

  // the sentinel header lives in registers, never in the RAM
  `FFA_ASSERT_NOW(a_no_sentinel_wr, mem_req.we, mem_req.addr != '0,
    "header write to sentinel entry")
  `FFA_ASSERT_NOW(a_oom_not_reuse, out_valid_r, !(out_status_r && out_from_list_r),
    "out of memory and reuse on one beat")
  `FFA_ASSERT_NOW(a_free_result, out_valid_r && func_r,
    out_addr_r == '0 && !out_status_r && !out_from_list_r,
    "free beat with nonzero fields")
  `FFA_ASSERT_NEXT(a_brk_grows, 1'b1, brk_r >= $past(brk_r),
    "heap break moved down")
  `FFA_ASSERT_NOW(a_walk_bound, state_r == ST_WALK, steps_r < SizeW'(HeapGranules),
    "walk ran past its bound")

endmodule

### rtl/first_fit_free_list_allocator_top.sv
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// First-fit explicit free-list heap allocator over 8-byte granules.
// ---------------------------------------------------------------------------
//  channel | handshake             | beat
//  in_     | start && !busy        | in_func, in_req_size, in_free_addr
//  out_    | out_valid (1 cycle)   | out_addr, out_status, out_from_list
//  cfg_    | cfg_valid && cfg_ready| cfg_data (heap limit, granules)
//
//  One item at a time. Header RAM does one read or write per cycle and the
//  walk visits one free-list entry per cycle. Allocate takes the first
//  listed block that fits, else carves a new block at the break. Free
//  marks the block unused and pushes it on the list head. Sync reset
//  empties the list and puts the break past the sentinel; the header RAM
//  is not cleared. The receiver cannot stall the out_ beat.
// ---------------------------------------------------------------------------
module first_fit_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_free_addr,
  output logic        out_valid,
  output logic [15:0] out_addr,
  output logic        out_status,
  output logic        out_from_list,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data
);
  import ffa_pkg::*;

  logic [SizeW-1:0] limit_r;
  mem_req_t         mem_req;
  hdr_t             mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= SizeW'(HeapGranules);
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  assign cfg_ready = !busy;

  ffa_hdr_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ffa_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_req_size   (in_req_size),
    .in_free_addr  (in_free_addr),
    .limit         (limit_r),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .out_valid     (out_valid),
    .out_addr      (out_addr),
    .out_status    (out_status),
    .out_from_list (out_from_list)
  );

endmodule
